// ----- hdl/sitoa_pkg.sv -----
// Shared constants, types and helper functions for the integer to text converter.
package sitoa_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 32;

    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_BITS    = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'd45;
    localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd87;
    localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = 6'd10;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_RD,
        BK_LD
    } t_back_state;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] c;
        c = r;
        if (r < RADIX_MIN) begin
            c = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            c = RADIX_MAX;
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] char_of_digit(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DECIMAL_LIMIT) begin
            c = CHAR_W'(d) + LETTER_OFFSET;
        end else begin
            c = CHAR_W'(d) + CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

// ----- hdl/sitoa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module sitoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/sitoa_front.sv -----
// Front end: accepts an input item, splits it into sign and unsigned magnitude.
module sitoa_front #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_push,
    input  logic                  i_push_ready,
    output logic [VALUE_BITS:0]   o_push_data
);

    import sitoa_pkg::*;

    logic                  r_valid;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  accept;

    assign o_in_stall = r_valid && !i_push_ready;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= i_value[VALUE_BITS-1];
            r_mag <= i_value[VALUE_BITS-1] ? (~i_value + VALUE_BITS'(1)) : i_value;
        end
    end

    assign o_push      = r_valid;
    assign o_push_data = {r_neg, r_mag};

endmodule

// ----- hdl/sitoa_queue.sv -----
// Short queue between the front end and the conversion back end.
module sitoa_queue #(
    parameter int WIDTH = sitoa_pkg::VALUE_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data
);

    import sitoa_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_count != NW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- hdl/sitoa_back.sv -----
// Back end: divides out digits into the digit store, then emits characters.
module sitoa_back #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = sitoa_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [sitoa_pkg::RADIX_W-1:0]   i_radix,
    input  logic                            i_pop_valid,
    output logic                            o_pop,
    input  logic [VALUE_BITS:0]             i_pop_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sitoa_pkg::CHAR_W-1:0]    o_char_code,
    output logic                            o_last
);

    import sitoa_pkg::*;

    localparam int DIV_STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W     = DIV_STEPS * DIV_BITS;
    localparam int SW        = $clog2(DIV_STEPS + 1);
    localparam int CW        = $clog2(MAX_DIGITS + 1);
    localparam int AW        = $clog2(MAX_DIGITS);

    t_back_state        r_state, n_state;
    logic [PAD_W-1:0]   r_quot, n_quot;
    logic [RADIX_W-1:0] r_rem, n_rem;
    logic [SW-1:0]      r_step, n_step;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic               r_ov, n_ov;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;

    logic               wr_en;
    logic               rd_en;
    logic [RADIX_W-1:0] rd_data;
    logic [CW-1:0]      cnt_m1;
    logic [PAD_W-1:0]   qv;
    logic [RADIX_W-1:0] rv;
    logic [RADIX_W:0]   rem7;
    logic               out_free;

    assign cnt_m1   = r_cnt - CW'(1);
    assign out_free = !r_ov || !i_out_stall;

    sitoa_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (rv),
        .i_rd_en   (rd_en),
        .i_rd_addr (cnt_m1[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_step  <= '0;
            r_neg   <= 1'b0;
            r_quot  <= '0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_neg   <= n_neg;
            r_quot  <= n_quot;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    always_comb begin
        n_state = r_state;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_ov    = r_ov;
        n_char  = r_char;
        n_last  = r_last;
        o_pop   = 1'b0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;

        // restoring division, DIV_BITS quotient bits per cycle
        qv = r_quot;
        rv = r_rem;
        for (int k = 0; k < DIV_BITS; k++) begin
            rem7 = {rv, qv[PAD_W-1]};
            qv   = {qv[PAD_W-2:0], 1'b0};
            if (rem7 >= {1'b0, i_radix}) begin
                rem7  = rem7 - {1'b0, i_radix};
                qv[0] = 1'b1;
            end
            rv = rem7[RADIX_W-1:0];
        end

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            BK_IDLE: begin
                if (i_pop_valid) begin
                    o_pop   = 1'b1;
                    n_neg   = i_pop_data[VALUE_BITS];
                    n_quot  = PAD_W'(i_pop_data[VALUE_BITS-1:0]);
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                n_quot = qv;
                n_rem  = rv;
                n_step = r_step + SW'(1);
                if (r_step == SW'(DIV_STEPS - 1)) begin
                    wr_en  = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_step = '0;
                    n_rem  = '0;
                    if ((qv == '0) || (n_cnt == CW'(MAX_DIGITS))) begin
                        n_state = r_neg ? BK_SIGN : BK_RD;
                    end
                end
            end
            BK_SIGN: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_char  = CHAR_MINUS;
                    n_last  = 1'b0;
                    n_state = BK_RD;
                end
            end
            BK_RD: begin
                rd_en   = 1'b1;
                n_state = BK_LD;
            end
            BK_LD: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_char  = char_of_digit(rd_data);
                    n_last  = (r_cnt == CW'(1));
                    n_cnt   = cnt_m1;
                    n_state = (r_cnt == CW'(1)) ? BK_IDLE : BK_RD;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

// ----- hdl/signed_integer_to_ascii_radix.sv -----
// Top level: converts signed integers to ASCII text in a programmable radix.
//
// Each accepted value is emitted as a run of ASCII characters, most significant
// first, with a leading '-' for negative values and o_last set on the final
// character. The radix register (reset 10) is clamped to 2..36; digits above 9
// come out as 'a'..'z'. A front stage takes the value and forms its magnitude,
// a two-entry queue holds pending values, and the back end does the work: each
// digit comes from a full pass of the shared restoring divider (8 quotient
// bits per cycle) and is written to the digit store; the characters are then
// read back through the digit store's registered read port, after a minus
// sign for a negative value. The front end keeps accepting items while the
// queue has room.
module signed_integer_to_ascii_radix #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = sitoa_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [VALUE_BITS-1:0]         i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sitoa_pkg::CHAR_W-1:0]  o_char_code,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sitoa_pkg::RADIX_W-1:0] i_cfg_radix
);

    import sitoa_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic [RADIX_W-1:0] radix_eff;
    logic               push;
    logic               push_ready;
    logic [VALUE_BITS:0] push_data;
    logic               pop_valid;
    logic               pop;
    logic [VALUE_BITS:0] pop_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_radix;
        end
    end

    assign radix_eff = clamp_radix(r_radix);

    sitoa_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (i_value),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    sitoa_queue #(
        .WIDTH (VALUE_BITS + 1)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_data   (pop_data)
    );

    sitoa_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix     (radix_eff),
        .i_pop_valid (pop_valid),
        .o_pop       (pop),
        .i_pop_data  (pop_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for signed_integer_to_ascii_radix: directed table, random phases, text predictor.
module tb;
    import sitoa_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char;

    typedef struct {
        logic [RADIX_W-1:0] radix;
        logic [31:0]        value;
        string              text;
    } t_row;

    localparam int DIR_ROWS     = 24;
    localparam int PHASES       = 11;
    localparam int PHASE_ITEMS  = 40;
    localparam int MAX_DIGITS   = 32;
    localparam int HOLD_CYCLES  = 400;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [31:0]         i_value     = '0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [RADIX_W-1:0]  i_cfg_radix = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [CHAR_W-1:0]   o_char_code;
    logic                o_last;
    logic                o_cfg_ready;

    t_char               expected_text[$];
    logic [RADIX_W-1:0]  radix_now = RADIX_RESET;
    int                  mismatch_count = 0;
    int                  chars_seen = 0;
    bit                  in_calm = 1'b0;
    bit                  out_calm = 1'b0;

    t_row dir_rows [0:DIR_ROWS-1] = '{
        '{6'd10, 32'd0,          "0"},
        '{6'd10, 32'd1,          "1"},
        '{6'd10, 32'hffff_ffff,  "-1"},
        '{6'd10, 32'd9,          "9"},
        '{6'd10, 32'd10,         "10"},
        '{6'd10, 32'hffff_fff6,  "-10"},
        '{6'd10, 32'h7fff_ffff,  "2147483647"},
        '{6'd10, 32'h8000_0000,  "-2147483648"},
        '{6'd10, 32'd12345,      ""},
        '{6'd10, 32'hc521_974f,  ""},
        '{6'd2,  32'd0,          "0"},
        '{6'd2,  32'h7fff_ffff,  "1111111111111111111111111111111"},
        '{6'd2,  32'h8000_0000,  "-10000000000000000000000000000000"},
        '{6'd2,  32'hffff_ffff,  "-1"},
        '{6'd36, 32'd35,         "z"},
        '{6'd36, 32'h7fff_ffff,  "zik0zj"},
        '{6'd36, 32'h8000_0000,  "-zik0zk"},
        '{6'd36, 32'hffff_ffdc,  "-10"},
        '{6'd0,  32'd5,          "101"},
        '{6'd1,  32'hffff_fffa,  "-110"},
        '{6'd63, 32'd35,         "z"},
        '{6'd37, 32'd36,         "10"},
        '{6'd16, 32'hdead_beef,  ""},
        '{6'd7,  32'd123456789,  ""}
    };

    signed_integer_to_ascii_radix dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_radix (i_cfg_radix)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_text(input logic [31:0] value, input logic [RADIX_W-1:0] radix);
        logic [RADIX_W-1:0] base;
        logic [31:0]        mag;
        logic [RADIX_W-1:0] digits[$];
        logic [RADIX_W-1:0] d;
        t_char              c;
        base = radix;
        if (radix < 6'd2) begin
            base = 6'd2;
        end else if (radix > 6'd36) begin
            base = 6'd36;
        end
        mag = value[31] ? (32'd0 - value) : value;
        do begin
            digits.push_front(RADIX_W'(mag % 32'(base)));
            mag = mag / 32'(base);
        end while (mag != 0 && digits.size() < MAX_DIGITS);
        if (value[31]) begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        foreach (digits[i]) begin
            d = digits[i];
            c.code = (d >= 6'd10) ? CHAR_W'(d) + LETTER_OFFSET : CHAR_W'(d) + CHAR_ZERO;
            c.last = (i == digits.size() - 1);
            expected_text.push_back(c);
        end
    endfunction

    function automatic logic [31:0] draw_value();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = $urandom_range(0, 40);
            1: v = 32'd0 - $urandom_range(1, 40);
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'd0;
                    default: v = 32'hffff_ffff;
                endcase
            end
            3: begin
                v = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
                if ($urandom_range(0, 1) == 1) begin
                    v = 32'd0 - v;
                end
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // offer one item after a random gap; predict once it is taken
    task automatic send_value(input logic [31:0] value, input string text);
        int   gap;
        t_char c;
        gap = in_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        if (text.len() == 0) begin
            predict_text(value, radix_now);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                c.code = text[i];
                c.last = (i == text.len() - 1);
                expected_text.push_back(c);
            end
        end
    endtask

    // drain every outstanding item before touching the radix
    task automatic set_radix(input logic [RADIX_W-1:0] r);
        i_in_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_radix <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        radix_now = r;
    endtask

    initial begin : char_sink
        int    hold;
        t_char want;
        wait (i_rst_n);
        forever begin
            if (chars_seen % 40 == 0) begin
                out_calm = ($urandom_range(0, 3) == 0);
            end
            if (chars_seen == 600 || chars_seen == 2400) begin
                hold = HOLD_CYCLES;
            end else begin
                hold = out_calm ? 0 : $urandom_range(0, 10);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            chars_seen++;
            if (expected_text.size() == 0) begin
                $error("unexpected item: char_code 0x%02h last %0b", o_char_code, o_last);
                mismatch_count++;
            end else begin
                want = expected_text.pop_front();
                if (o_char_code !== want.code) begin
                    $error("char_code: expected 0x%02h, got 0x%02h", want.code, o_char_code);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [RADIX_W-1:0] r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].radix != radix_now) begin
                set_radix(dir_rows[k].radix);
            end
            send_value(dir_rows[k].value, dir_rows[k].text);
        end
        for (int p = 0; p < PHASES; p++) begin
            r = ($urandom_range(0, 4) == 0) ? RADIX_W'($urandom_range(0, 63))
                                             : RADIX_W'($urandom_range(2, 36));
            set_radix(r);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0) begin
                    in_calm = ($urandom_range(0, 2) == 0);
                end
                send_value(draw_value(), "");
            end
        end
        i_in_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** signed_integer_to_ascii_radix: PASSED **");
        end else begin
            $display("** signed_integer_to_ascii_radix: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("** signed_integer_to_ascii_radix: FAILED **");
        $finish;
    end

endmodule
